/* rtl/core/mfde_pkg.sv */
// package for the monochrome frame store draw engine
// request codes, request record and memory control struct; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mfde_pkg;

    localparam logic [2:0] REQ_PIXEL   = 3'd0;
    localparam logic [2:0] REQ_RECT    = 3'd1;
    localparam logic [2:0] REQ_PATTERN = 3'd2;
    localparam logic [2:0] REQ_FILL    = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;

    localparam int PAT_BITS = 16;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  width;
        logic [7:0]  height;
        logic        color;
        logic [15:0] pattern;
        logic        lsb_first;
        logic        opaque;
    } t_req;

    typedef struct packed {
        logic en;
        logic we;
    } t_ram_ctl;

endpackage

`default_nettype wire

/* rtl/core/mfde_ram.sv */
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mfde_walk.sv */
// draw sequencer: clips a request and walks the frame store bytes one at a time
// uses mfde_pkg; drives the single port of mfde_ram, by read-modify-write for pixel work
`timescale 1ns / 1ps
`default_nettype none

module mfde_walk #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8,
    localparam int DEPTH = SCREEN_WIDTH * PAGES,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire mfde_pkg::t_req     i_req,
    input  wire logic               i_invert,
    output logic                    o_ready,
    output mfde_pkg::t_ram_ctl      o_ram_ctl,
    output logic [AW-1:0]           o_ram_addr,
    output logic [7:0]              o_ram_wdata,
    input  wire logic [7:0]         i_ram_rdata,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output logic [7:0]              o_res_data
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PLAN   = 4'd2;
    localparam logic [3:0] S_RMW_RD = 4'd3;
    localparam logic [3:0] S_RMW_WR = 4'd4;
    localparam logic [3:0] S_FILL   = 4'd5;
    localparam logic [3:0] S_RREQ   = 4'd6;
    localparam logic [3:0] S_RDATA  = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROW_STEP  = AW'(SCREEN_WIDTH);

    logic [3:0]         r_state, n_state;
    mfde_pkg::t_req     r_req, n_req;
    logic [7:0]         r_col, n_col;
    logic [7:0]         r_col_end, n_col_end;
    logic [PGW-1:0]     r_page, n_page;
    logic [PGW-1:0]     r_page_end, n_page_end;
    logic [7:0]         r_yhi, n_yhi;
    logic [AW-1:0]      r_addr, n_addr;
    logic [AW-1:0]      r_row_base, n_row_base;
    logic [3:0]         r_idx, n_idx;
    logic [7:0]         r_fill, n_fill;
    logic [7:0]         r_rd, n_rd;

    // clipping terms, all taken from the latched request
    logic               is_pix, is_pat, is_draw;
    logic [7:0]         w_eff, h_eff, ylim;
    logic [8:0]         xe9, ye9;
    logic               empty, read_ok;
    logic [PGW-1:0]     mul_page;
    logic [PGW+7:0]     prod;
    logic [AW-1:0]      base;

    // byte merge terms
    logic [7:0]         mask, merged, row_v;
    logic               pbit, base_color, wr_color, wr_en;

    always_comb begin
        is_pix  = (r_req.req_type == mfde_pkg::REQ_PIXEL);
        is_pat  = (r_req.req_type == mfde_pkg::REQ_PATTERN);
        is_draw = is_pix || is_pat || (r_req.req_type == mfde_pkg::REQ_RECT);

        if (is_pix) begin
            w_eff = 8'd1;
        end else if (is_pat && r_req.width > 8'(mfde_pkg::PAT_BITS)) begin
            w_eff = 8'(mfde_pkg::PAT_BITS);
        end else begin
            w_eff = r_req.width;
        end
        h_eff = (is_pix || is_pat) ? 8'd1 : r_req.height;

        xe9  = {1'b0, r_req.x} + {1'b0, w_eff};
        ye9  = {1'b0, r_req.y} + {1'b0, h_eff};
        ylim = (ye9 > 9'(SCREEN_HEIGHT)) ? 8'(SCREEN_HEIGHT) : ye9[7:0];

        empty = (r_req.x >= 8'(SCREEN_WIDTH)) || (r_req.y >= 8'(SCREEN_HEIGHT))
              || (w_eff == 8'd0) || (h_eff == 8'd0);
        read_ok = (r_req.x < 8'(SCREEN_WIDTH)) && (r_req.y < 8'(PAGES));

        // the one multiplier: page times row pitch
        mul_page = (r_req.req_type == mfde_pkg::REQ_READ) ? PGW'(r_req.y)
                                                           : PGW'(r_req.y >> 3);
        prod = (PGW + 8)'(mul_page) * (PGW + 8)'(SCREEN_WIDTH);
        base = AW'(prod) + AW'(r_req.x);
    end

    always_comb begin
        row_v = 8'd0;
        for (int k = 0; k < 8; k++) begin
            row_v   = 8'({r_page, 3'b000}) | 8'(k);
            mask[k] = (row_v >= r_req.y) && (row_v <= r_yhi);
        end

        pbit = r_req.lsb_first ? r_req.pattern[r_idx] : r_req.pattern[4'd15 - r_idx];
        base_color = r_req.color ^ i_invert;
        if (is_pat && !pbit) begin
            wr_en    = r_req.opaque;
            wr_color = ~base_color;
        end else begin
            wr_en    = 1'b1;
            wr_color = base_color;
        end
        merged = wr_color ? (i_ram_rdata | mask) : (i_ram_rdata & ~mask);
    end

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_col      = r_col;
        n_col_end  = r_col_end;
        n_page     = r_page;
        n_page_end = r_page_end;
        n_yhi      = r_yhi;
        n_addr     = r_addr;
        n_row_base = r_row_base;
        n_idx      = r_idx;
        n_fill     = r_fill;
        n_rd       = r_rd;

        o_ram_ctl   = '0;
        o_ram_addr  = r_addr;
        o_ram_wdata = 8'd0;

        unique case (r_state)
            S_CLEAR: begin
                o_ram_ctl = '{en: 1'b1, we: 1'b1};
                n_addr    = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_rd    = 8'd0;
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_col      = r_req.x;
                n_col_end  = (xe9 > 9'(SCREEN_WIDTH)) ? 8'(SCREEN_WIDTH) : xe9[7:0];
                n_page     = PGW'(r_req.y >> 3);
                n_yhi      = ylim - 8'd1;
                n_page_end = PGW'(n_yhi >> 3);
                n_addr     = base;
                n_row_base = base;
                n_idx      = 4'd0;
                n_fill     = {8{r_req.color}};
                n_state    = S_DONE;
                if (is_draw && !empty) begin
                    n_state = S_RMW_RD;
                end else if (r_req.req_type == mfde_pkg::REQ_FILL) begin
                    n_addr  = '0;
                    n_state = S_FILL;
                end else if (r_req.req_type == mfde_pkg::REQ_READ && read_ok) begin
                    n_state = S_RREQ;
                end
            end
            S_RMW_RD: begin
                o_ram_ctl = '{en: 1'b1, we: 1'b0};
                n_state   = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_ram_ctl   = '{en: wr_en, we: wr_en};
                o_ram_wdata = merged;
                if ({1'b0, r_col} + 9'd1 < {1'b0, r_col_end}) begin
                    n_col   = r_col + 8'd1;
                    n_addr  = r_addr + AW'(1);
                    n_idx   = r_idx + 4'd1;
                    n_state = S_RMW_RD;
                end else if (r_page != r_page_end) begin
                    // next page: back to the first column, one row pitch down
                    n_page     = r_page + PGW'(1);
                    n_col      = r_req.x;
                    n_addr     = r_row_base + ROW_STEP;
                    n_row_base = r_row_base + ROW_STEP;
                    n_idx      = 4'd0;
                    n_state    = S_RMW_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FILL: begin
                o_ram_ctl   = '{en: 1'b1, we: 1'b1};
                o_ram_wdata = r_fill;
                n_addr      = r_addr + AW'(1);
                if (r_addr == LAST_ADDR) begin
                    n_state = S_DONE;
                end
            end
            S_RREQ: begin
                o_ram_ctl = '{en: 1'b1, we: 1'b0};
                n_state   = S_RDATA;
            end
            S_RDATA: begin
                n_rd    = i_ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_col      <= n_col;
        r_col_end  <= n_col_end;
        r_page     <= n_page;
        r_page_end <= n_page_end;
        r_yhi      <= n_yhi;
        r_row_base <= n_row_base;
        r_idx      <= n_idx;
        r_fill     <= n_fill;
        r_rd       <= n_rd;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res_data  = r_rd;

endmodule

`default_nettype wire

/* rtl/core/mono_framebuffer_draw_engine.sv */
// top level of the monochrome frame store draw engine
// uses mfde_pkg, mfde_walk and mfde_ram
`timescale 1ns / 1ps
`default_nettype none

// Page-organized monochrome frame store (byte = x + (y/8)*SCREEN_WIDTH, bit y%8)
// with a draw engine that takes one request at a time and returns one word per
// request. All pixel work is read-modify-write on a single-port memory with a
// registered read: each byte touched is read in S_RMW_RD and written back in
// S_RMW_WR. A pattern row or rectangle walks its clipped columns page by page,
// and a screen fill writes every byte of the store in order. After reset the
// store is cleared by a pass over every byte, during which no request is
// accepted; register writes are taken anytime.
// The result sits in an output register, so the next request may be accepted
// while the previous word still waits on the master side.
module mono_framebuffer_draw_engine #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x[7:0], y[15:8], width[23:16], height[31:24], color[32], pattern[48:33],
    // lsb_first[49], opaque[50], zero pad [55:51]
    input  wire logic [55:0] s_axis_tdata,
    // req_type[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data[7:0], done_res[8], zero pad [15:9]
    output logic [15:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH = SCREEN_WIDTH * PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               r_invert;
    logic               r_out_valid;
    logic [7:0]         r_out_data;

    mfde_pkg::t_req     req;
    mfde_pkg::t_ram_ctl ram_ctl;
    logic [AW-1:0]      ram_addr;
    logic [7:0]         ram_wdata, ram_rdata;
    logic               walk_ready, res_valid, res_ready;
    logic [7:0]         res_data;
    logic               start, reg_sel;

    // register 0 sits at byte address 0; address 4 and up are outside the map
    assign reg_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {31'd0, r_invert} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b0;
        end else if (psel && penable && pwrite && reg_sel) begin
            r_invert <= pwdata[0];
        end
    end

    always_comb begin
        req.req_type  = s_axis_tuser;
        req.x         = s_axis_tdata[7:0];
        req.y         = s_axis_tdata[15:8];
        req.width     = s_axis_tdata[23:16];
        req.height    = s_axis_tdata[31:24];
        req.color     = s_axis_tdata[32];
        req.pattern   = s_axis_tdata[48:33];
        req.lsb_first = s_axis_tdata[49];
        req.opaque    = s_axis_tdata[50];
    end

    assign s_axis_tready = walk_ready;
    assign start         = s_axis_tvalid && walk_ready;

    mfde_walk #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_invert    (r_invert),
        .o_ready     (walk_ready),
        .o_ram_ctl   (ram_ctl),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .i_ram_rdata (ram_rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_data  (res_data)
    );

    mfde_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_ctl.en),
        .i_we    (ram_ctl.we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // output word register
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_data <= res_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, 1'b1, r_out_data};

endmodule

`default_nettype wire

/* rtl/core/mfde_checker.sv */
// port-level checks for mono_framebuffer_draw_engine, bound to the top level
// no package use; sees only the top-level ports
`timescale 1ns / 1ps
`default_nettype none

module mfde_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        psel,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // a waiting word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed or dropped while stalled");

    // every word reports completion with clean padding
    a_done_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:8] == 8'h01))
        else $error("output word without done flag");

    // one request at a time: ready drops right after an accept
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // register bus never stalls and only the invert bit reads back
    a_apb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready && (prdata[31:1] == 31'd0))
        else $error("register port stalled or returned stray bits");

endmodule

bind mono_framebuffer_draw_engine mfde_checker u_mfde_checker (.*);

`default_nettype wire
